### rtl/ple_pkg.sv
// Shared types and codes for the positional list engine.
// Holds command and status codes and the controller/datapath interface structs.
// No dependencies.
package ple_pkg;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_GET    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the accepted beat
      logic eval;       // latch the status of the captured command
      logic cnt_clear;
      logic cnt_inc;
      logic cnt_dec;
      logic wr_value;   // write the captured word at position - 1
      logic rd_get;     // read the entry at position - 1
      logic cur_init;   // set up the shift cursor
      logic shift_rd;   // read at the cursor and step it
      logic rsp_load;   // load the result register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type    command;
      status_type status;
      logic       insert_append;  // insert lands right after the last entry
      logic       delete_at_end;  // delete removes the last entry
      logic       shift_last;     // the cursor is on the last entry to move
   } ctrl_sts_type;

endpackage

### rtl/positional_list_engine.sv
// Clear, get, errors, an append and a delete of the last entry need no shift; any other insert
// or delete moves the entries behind the position before its response. A new request beat is
// taken only once the last command has loaded its response. The entry memory moves one word per
// cycle during the shift through one read and one write port.
// Synchronous active-high reset empties the list at once (count zero); no clearing pass is run.
// Top level of the positional list engine. Depends on ple_pkg, ple_ctrl and ple_dpath.
module positional_list_engine #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // Fields from bit 0: position, value.
   input  logic [(($clog2(DEPTH+2)+32+7)/8)*8-1:0]    req_tdata,
   // Fields from bit 0: command.
   input  logic [1:0]                                 req_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // Fields from bit 0: read_value, count.
   output logic [(($clog2(DEPTH+1)+32+7)/8)*8-1:0]    rsp_tdata,
   // Fields from bit 0: status.
   output logic [1:0]                                 rsp_tuser
);
   import ple_pkg::*;

   localparam int unsigned PW    = $clog2(DEPTH + 2);
   localparam int unsigned CW    = $clog2(DEPTH + 1);
   localparam int unsigned OUT_W = ((CW + 32 + 7) / 8) * 8;

   ctrl_cmd_type       ctrl_cmd;
   ctrl_sts_type       ctrl_sts;
   cmd_type            req_command;
   logic [PW-1:0]      req_position;
   logic signed [31:0] req_value;
   status_type         rsp_status;
   logic signed [31:0] rsp_read_value;
   logic [CW-1:0]      rsp_count;

   // Unpack the request beat; the padding bits above value are ignored.
   assign req_command  = cmd_type'(req_tuser);
   assign req_position = req_tdata[PW-1:0];
   assign req_value    = $signed(req_tdata[PW+31:PW]);

   // Pack the response beat, zero filled up to whole bytes.
   assign rsp_tdata = OUT_W'({rsp_count, rsp_read_value});
   assign rsp_tuser = rsp_status;

   // The controller steps through evaluate, shift, drain, put and finish phases and
   // holds the response valid flag; the datapath owns every payload register.
   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl_cmd   (ctrl_cmd),
      .ctrl_sts   (ctrl_sts)
   );

   ple_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .ctrl_cmd       (ctrl_cmd),
      .ctrl_sts       (ctrl_sts),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

endmodule

### rtl/ple_dpath.sv
// Datapath of the positional list engine: entry memory, count, shift cursor
// and result register. Depends on ple_pkg; driven by ple_ctrl.
module ple_dpath #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ple_pkg::ctrl_cmd_type         ctrl_cmd,
   output ple_pkg::ctrl_sts_type         ctrl_sts,
   input  ple_pkg::cmd_type              req_command,
   input  logic [$clog2(DEPTH+2)-1:0]    req_position,
   input  logic signed [31:0]            req_value,
   output ple_pkg::status_type           rsp_status,
   output logic signed [31:0]            rsp_read_value,
   output logic [$clog2(DEPTH+1)-1:0]    rsp_count
);
   import ple_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned PW = $clog2(DEPTH + 2);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   cmd_type            cmd_ff;
   logic [PW-1:0]      pos_ff;
   logic signed [31:0] val_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      cursor_ff, cursor_in;
   logic [AW-1:0]      dest_ff, dest_in;
   logic               pend_ff;
   logic signed [31:0] rdata_ff;
   status_type         status_ff;
   status_type         status_now;
   status_type         rsp_status_ff;
   logic signed [31:0] rsp_value_ff;
   logic [CW-1:0]      rsp_count_ff;
   logic signed [31:0] entries_ff [DEPTH];

   logic [PW:0]   cnt_p1;
   logic [PW:0]   cnt_x;
   logic [PW:0]   pos_x;
   logic          pos_zero;
   logic          ins_ok;
   logic          acc_ok;
   logic          full;
   logic [AW-1:0] pos_idx;
   logic [AW-1:0] cnt_m1_idx;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          is_insert;

   assign is_insert  = (cmd_ff == CMD_INSERT);
   assign cnt_x      = (PW+1)'(count_ff);
   assign cnt_p1     = cnt_x + (PW+1)'(1);
   assign pos_x      = (PW+1)'(pos_ff);
   assign pos_zero   = (pos_ff == '0);
   assign ins_ok     = !pos_zero && (pos_x <= cnt_p1);
   assign acc_ok     = !pos_zero && (pos_x <= cnt_x);
   assign full       = (count_ff == CW'(DEPTH));
   assign pos_idx    = AW'(pos_ff - PW'(1));
   assign cnt_m1_idx = AW'(count_ff - CW'(1));

   always_comb begin
      case (cmd_ff)
         CMD_CLEAR: begin
            status_now = ST_OK;
         end
         CMD_INSERT: begin
            if (!ins_ok) begin
               status_now = ST_BAD_POS;
            end else if (full) begin
               status_now = ST_FULL;
            end else begin
               status_now = ST_OK;
            end
         end
         default: begin
            status_now = acc_ok ? ST_OK : ST_BAD_POS;
         end
      endcase
   end

   always_comb begin
      ctrl_sts.command       = cmd_ff;
      ctrl_sts.status        = status_now;
      ctrl_sts.insert_append = (pos_x == cnt_p1);
      ctrl_sts.delete_at_end = (pos_x == cnt_x);
      ctrl_sts.shift_last    = is_insert ? (cursor_ff == pos_idx)
                                         : (cursor_ff == cnt_m1_idx);
   end

   // Captured beat and latched status.
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         cmd_ff <= req_command;
         pos_ff <= req_position;
         val_ff <= req_value;
      end
      if (ctrl_cmd.eval) begin
         status_ff <= status_now;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl_cmd.cnt_clear) begin
         count_in = '0;
      end else if (ctrl_cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl_cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Insert walks the cursor down from the last entry, delete walks it up
   // from the entry after the removed one.
   always_comb begin
      cursor_in = cursor_ff;
      dest_in   = dest_ff;
      if (ctrl_cmd.cur_init) begin
         cursor_in = is_insert ? cnt_m1_idx : AW'(pos_ff);
      end else if (ctrl_cmd.shift_rd) begin
         cursor_in = is_insert ? cursor_ff - AW'(1) : cursor_ff + AW'(1);
         dest_in   = is_insert ? cursor_ff + AW'(1) : cursor_ff - AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= ctrl_cmd.shift_rd;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      dest_ff   <= dest_in;
   end

   assign rd_en   = ctrl_cmd.rd_get || ctrl_cmd.shift_rd;
   assign rd_addr = ctrl_cmd.shift_rd ? cursor_ff : pos_idx;

   // A word read during the shift is written to its new place in the following cycle.
   always_ff @(posedge clock) begin
      if (pend_ff) begin
         entries_ff[dest_ff] <= rdata_ff;
      end else if (ctrl_cmd.wr_value) begin
         entries_ff[pos_idx] <= val_ff;
      end
      if (rd_en) begin
         rdata_ff <= entries_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= (cmd_ff == CMD_GET && status_ff == ST_OK) ? rdata_ff : 32'sd0;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_count      = rsp_count_ff;

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && ctrl_cmd.wr_value))
      else $error("shift write and value write in the same cycle");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_count_inc: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.cnt_inc |=> count_ff == $past(count_ff) + CW'(1))
      else $error("entry count did not step up after insert");

endmodule

### rtl/ple_ctrl.sv
// Controller of the positional list engine: sequences each command and owns
// the stream handshakes. Depends on ple_pkg; drives ple_dpath.
module ple_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ple_pkg::ctrl_cmd_type ctrl_cmd,
   input  ple_pkg::ctrl_sts_type ctrl_sts
);
   import ple_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_EVAL   = 6'b000010,
      S_SHIFT  = 6'b000100,
      S_DRAIN  = 6'b001000,
      S_PUT    = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      ctrl_cmd     = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctrl_cmd.load = 1'b1;
               state_in      = S_EVAL;
            end
         end
         S_EVAL: begin
            ctrl_cmd.eval = 1'b1;
            state_in      = S_FINISH;
            case (ctrl_sts.command)
               CMD_CLEAR: begin
                  ctrl_cmd.cnt_clear = 1'b1;
               end
               CMD_INSERT: begin
                  if (ctrl_sts.status == ST_OK) begin
                     if (ctrl_sts.insert_append) begin
                        ctrl_cmd.wr_value = 1'b1;
                        ctrl_cmd.cnt_inc  = 1'b1;
                     end else begin
                        ctrl_cmd.cur_init = 1'b1;
                        state_in          = S_SHIFT;
                     end
                  end
               end
               CMD_DELETE: begin
                  if (ctrl_sts.status == ST_OK) begin
                     if (ctrl_sts.delete_at_end) begin
                        ctrl_cmd.cnt_dec = 1'b1;
                     end else begin
                        ctrl_cmd.cur_init = 1'b1;
                        state_in          = S_SHIFT;
                     end
                  end
               end
               default: begin
                  ctrl_cmd.rd_get = (ctrl_sts.status == ST_OK);
               end
            endcase
         end
         S_SHIFT: begin
            ctrl_cmd.shift_rd = 1'b1;
            if (ctrl_sts.shift_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The datapath writes the last moved word in this cycle.
            if (ctrl_sts.command == CMD_INSERT) begin
               state_in = S_PUT;
            end else begin
               ctrl_cmd.cnt_dec = 1'b1;
               state_in         = S_FINISH;
            end
         end
         S_PUT: begin
            ctrl_cmd.wr_value = 1'b1;
            ctrl_cmd.cnt_inc  = 1'b1;
            state_in          = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               ctrl_cmd.rsp_load = 1'b1;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
